>>> rtl/ray_triangle_intersect_core_macros.svh
// ============================================================================
// Assertion macros for the ray/triangle intersection core
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ============================================================================
`ifndef RAY_TRIANGLE_INTERSECT_CORE_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RTIC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RTIC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rtic_pkg.sv
// ============================================================================
// rtic_pkg
// Types, micro-operation codes, register file map and the micro-program of
// the ray/triangle intersection core.
// ============================================================================
package rtic_pkg;

    localparam int ADDR_W   = 6;
    localparam int PC_W     = 7;
    localparam int PROG_LEN = 114;
    localparam int COPY_W   = 4;
    localparam logic [COPY_W-1:0] COPY_LAST = 4'd14;

    localparam int DIST_BITS    = 32;
    localparam int HIT_DIV_BITS = 41;
    localparam int HIT_FRAC     = 8;
    localparam int DIV_CNT_W    = 6;
    localparam int HIT_SUM_W    = 43;
    localparam logic signed [HIT_SUM_W-1:0] HIT_MAX = 43'sh07F_FFFF_FFFF;
    localparam logic signed [HIT_SUM_W-1:0] HIT_MIN = 43'sh780_0000_0000;

    localparam logic [2:0] OP_SUB   = 3'd0;
    localparam logic [2:0] OP_ABS   = 3'd1;
    localparam logic [2:0] OP_MULC  = 3'd2;
    localparam logic [2:0] OP_MULA  = 3'd3;
    localparam logic [2:0] OP_MULS  = 3'd4;
    localparam logic [2:0] OP_STORE = 3'd5;
    localparam logic [2:0] OP_DIV   = 3'd6;
    localparam logic [2:0] OP_END   = 3'd7;

    localparam logic [2:0] TAG_NONE = 3'd0;
    localparam logic [2:0] TAG_DEN  = 3'd1;
    localparam logic [2:0] TAG_NUM  = 3'd2;
    localparam logic [2:0] TAG_TV   = 3'd3;
    localparam logic [2:0] TAG_DIST = 3'd4;
    localparam logic [2:0] TAG_HX   = 3'd5;
    localparam logic [2:0] TAG_HY   = 3'd6;
    localparam logic [2:0] TAG_HZ   = 3'd7;

    localparam logic [1:0] OUTCOME_HIT      = 2'd0;
    localparam logic [1:0] OUTCOME_PARALLEL = 2'd1;
    localparam logic [1:0] OUTCOME_BEHIND   = 2'd2;
    localparam logic [1:0] OUTCOME_OUTSIDE  = 2'd3;

    localparam int A_V    = 0;
    localparam int A_O    = 9;
    localparam int A_D    = 12;
    localparam int A_E    = 15;
    localparam int A_N    = 24;
    localparam int A_M    = 27;
    localparam int A_T    = 36;
    localparam int A_DEN  = 39;
    localparam int A_NUM  = 40;
    localparam int A_R    = 41;
    localparam int A_DM   = 44;
    localparam int A_RM   = 47;
    localparam int A_AN   = 50;
    localparam int A_AD   = 51;
    localparam int A_ABSD = 52;
    localparam int A_P    = 55;

    typedef struct packed {
        logic              operation;
        logic [1:0]        vertex_slot;
        logic signed [15:0] vert_x;
        logic signed [15:0] vert_y;
        logic signed [15:0] vert_z;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic signed [15:0] origin_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [1:0]        outcome;
        logic [31:0]       distance;
        logic signed [39:0] hit_x;
        logic signed [39:0] hit_y;
        logic signed [39:0] hit_z;
    } rsp_t;

    typedef struct packed {
        logic [2:0]        op;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic [ADDR_W-1:0] dst;
        logic [2:0]        tag;
    } uop_t;

    typedef uop_t [PROG_LEN-1:0] prog_t;

    typedef struct packed {
        logic              load_vertex;
        logic              load_ray;
        logic              copy_en;
        logic [COPY_W-1:0] copy_idx;
        logic [ADDR_W-1:0] rd_a;
        logic [ADDR_W-1:0] rd_b;
        logic              exec;
        uop_t              uop;
        logic              mul_step;
        logic              div_step;
        logic              div_commit;
        logic              finish;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
    } status_t;

    function automatic uop_t mk(input logic [2:0] op, input int a, input int b,
                                input int dst, input logic [2:0] tag);
        uop_t u;
        u.op  = op;
        u.a   = ADDR_W'(a);
        u.b   = ADDR_W'(b);
        u.dst = ADDR_W'(dst);
        u.tag = tag;
        return u;
    endfunction

    function automatic prog_t build_prog();
        prog_t p;
        int    k;
        int    u;
        int    v;
        int    w;
        p = '0;
        k = 0;
        for (int i = 0; i < 3; i++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                p[k] = mk(OP_SUB, A_V + 3*((i+1)%3) + a, A_V + 3*i + a, A_E + 3*i + a,
                          TAG_NONE);
                k++;
            end
        end
        for (int j = 0; j < 4; j++)
        begin
            if (j == 0)
            begin
                u = A_E + 6;
                v = A_E;
                w = A_N;
            end
            else
            begin
                u = A_N;
                v = A_E + 3*(j-1);
                w = A_M + 3*(j-1);
            end
            for (int c = 0; c < 3; c++)
            begin
                p[k] = mk(OP_MULC, u + (c+1)%3, v + (c+2)%3, 0, TAG_NONE);
                k++;
                p[k] = mk(OP_MULS, u + (c+2)%3, v + (c+1)%3, 0, TAG_NONE);
                k++;
                p[k] = mk(OP_STORE, 0, 0, w + c, TAG_NONE);
                k++;
            end
        end
        p[k] = mk(OP_MULC, A_N, A_D, 0, TAG_NONE);
        k++;
        p[k] = mk(OP_MULA, A_N + 1, A_D + 1, 0, TAG_NONE);
        k++;
        p[k] = mk(OP_MULA, A_N + 2, A_D + 2, 0, TAG_NONE);
        k++;
        p[k] = mk(OP_STORE, 0, 0, A_DEN, TAG_DEN);
        k++;
        for (int a = 0; a < 3; a++)
        begin
            p[k] = mk(OP_SUB, A_V + a, A_O + a, A_T + a, TAG_NONE);
            k++;
        end
        p[k] = mk(OP_MULC, A_N, A_T, 0, TAG_NONE);
        k++;
        p[k] = mk(OP_MULA, A_N + 1, A_T + 1, 0, TAG_NONE);
        k++;
        p[k] = mk(OP_MULA, A_N + 2, A_T + 2, 0, TAG_NONE);
        k++;
        p[k] = mk(OP_STORE, 0, 0, A_NUM, TAG_NUM);
        k++;
        for (int i = 0; i < 3; i++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                p[k] = mk(OP_SUB, A_O + a, A_V + 3*i + a, A_R + a, TAG_NONE);
                k++;
            end
            for (int a = 0; a < 3; a++)
            begin
                p[k] = mk((a == 0) ? OP_MULC : OP_MULA, A_M + 3*i + a, A_R + a, 0, TAG_NONE);
                k++;
            end
            p[k] = mk(OP_STORE, 0, 0, A_RM + i, TAG_NONE);
            k++;
            for (int a = 0; a < 3; a++)
            begin
                p[k] = mk((a == 0) ? OP_MULC : OP_MULA, A_M + 3*i + a, A_D + a, 0, TAG_NONE);
                k++;
            end
            p[k] = mk(OP_STORE, 0, 0, A_DM + i, TAG_NONE);
            k++;
            p[k] = mk(OP_MULC, A_RM + i, A_DEN, 0, TAG_NONE);
            k++;
            p[k] = mk(OP_MULA, A_DM + i, A_NUM, 0, TAG_NONE);
            k++;
            p[k] = mk(OP_STORE, 0, 0, A_P, TAG_TV);
            k++;
        end
        p[k] = mk(OP_ABS, A_NUM, 0, A_AN, TAG_NONE);
        k++;
        p[k] = mk(OP_ABS, A_DEN, 0, A_AD, TAG_NONE);
        k++;
        p[k] = mk(OP_DIV, A_AN, A_AD, 0, TAG_DIST);
        k++;
        for (int a = 0; a < 3; a++)
        begin
            p[k] = mk(OP_ABS, A_D + a, 0, A_ABSD + a, TAG_NONE);
            k++;
            p[k] = mk(OP_MULC, A_AN, A_ABSD + a, 0, TAG_NONE);
            k++;
            p[k] = mk(OP_STORE, 0, 0, A_P + a, TAG_NONE);
            k++;
            p[k] = mk(OP_DIV, A_P + a, A_AD, 0, TAG_HX + 3'(a));
            k++;
        end
        p[k] = mk(OP_END, 0, 0, 0, TAG_NONE);
        return p;
    endfunction

    localparam prog_t PROG = build_prog();

endpackage

>>> rtl/ray_triangle_intersect_core.sv
// ============================================================================
// ray_triangle_intersect_core
// Holds one triangle loaded a vertex at a time and tests one-sided rays
// against it with exact integer edge tests.
// ============================================================================
//
//  Channel | Handshake              | Carries
//  --------+------------------------+-------------------------------------
//  req     | req_valid / req_stall  | vertex load or ray cast (req_t)
//  rsp     | rsp_valid / rsp_stall  | one result per cast (rsp_t)
//
// A vertex load leaves the core idle, so it never stalls, and produces no result.
// How long a cast takes depends on operand magnitudes and on whether the
// divisions saturate: a copy of the 15 ray and triangle coordinates, 114
// micro-operations on one register file read pair, a multiplier that retires
// 4 multiplier bits per cycle and a divider that produces one quotient bit
// per cycle.
// Reset clears the triangle to all zero; no clearing pass is needed.
// The request side is stalled while a cast is in progress; a finished result
// waits in its output register while rsp_stall is high.
module ray_triangle_intersect_core #(
    parameter int COORD_WIDTH    = 16,
    parameter int DIST_FRAC_BITS = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  rtic_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output rtic_pkg::rsp_t rsp_data
);

    rtic_pkg::cmd_t    cmd;
    rtic_pkg::status_t status;

    rtic_controller u_controller
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .operation (req_data.operation),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .status    (status)
    );

    rtic_datapath #(
        .COORD_WIDTH    (COORD_WIDTH),
        .DIST_FRAC_BITS (DIST_FRAC_BITS)
    ) u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req_data),
        .cmd      (cmd),
        .status   (status),
        .rsp_data (rsp_data)
    );

endmodule

>>> rtl/rtic_controller.sv
// ============================================================================
// rtic_controller
// Handshake control and micro-program sequencer of the intersection core.
// ============================================================================
module rtic_controller
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             operation,
    output logic             req_stall,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rtic_pkg::cmd_t   cmd,
    input  rtic_pkg::status_t status
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_COPY   = 3'd1;
    localparam logic [2:0] S_FETCH  = 3'd2;
    localparam logic [2:0] S_EXEC   = 3'd3;
    localparam logic [2:0] S_MUL    = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;
    logic [rtic_pkg::PC_W-1:0]     pc_reg;
    logic [rtic_pkg::PC_W-1:0]     pc_next;
    logic [rtic_pkg::COPY_W-1:0]   copy_reg;
    logic [rtic_pkg::COPY_W-1:0]   copy_next;
    logic                          rsp_valid_reg;
    logic                          rsp_valid_next;
    rtic_pkg::uop_t                uop;

    assign uop       = rtic_pkg::PROG[pc_reg];
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.rd_a     = uop.a;
        cmd.rd_b     = uop.b;
        cmd.uop      = uop;
        cmd.copy_idx = copy_reg;
        state_next   = state_reg;
        pc_next      = pc_reg;
        copy_next    = copy_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (operation)
                    begin
                        cmd.load_ray = 1'b1;
                        copy_next    = '0;
                        state_next   = S_COPY;
                    end
                    else
                    begin
                        cmd.load_vertex = 1'b1;
                    end
                end
            end
            S_COPY:
            begin
                cmd.copy_en = 1'b1;
                if (copy_reg == rtic_pkg::COPY_LAST)
                begin
                    pc_next    = '0;
                    state_next = S_FETCH;
                end
                else
                begin
                    copy_next = copy_reg + 1'b1;
                end
            end
            S_FETCH:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                unique case (uop.op) inside
                    rtic_pkg::OP_SUB, rtic_pkg::OP_ABS, rtic_pkg::OP_STORE:
                    begin
                        pc_next    = pc_reg + 1'b1;
                        state_next = S_FETCH;
                    end
                    rtic_pkg::OP_MULC, rtic_pkg::OP_MULA, rtic_pkg::OP_MULS:
                    begin
                        state_next = S_MUL;
                    end
                    rtic_pkg::OP_DIV:
                    begin
                        state_next = S_DIV;
                    end
                    rtic_pkg::OP_END:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_MUL:
            begin
                if (status.mul_done)
                begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = S_FETCH;
                end
                else
                begin
                    cmd.mul_step = 1'b1;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.div_commit = 1'b1;
                    pc_next        = pc_reg + 1'b1;
                    state_next     = S_FETCH;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            copy_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            copy_reg      <= copy_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

`include "ray_triangle_intersect_core_macros.svh"

    `RTIC_ASSERT_NOW(a_pc_in_program, (state_reg == S_FETCH) || (state_reg == S_EXEC), pc_reg < rtic_pkg::PC_W'(rtic_pkg::PROG_LEN), "Sequencer ran past the end of the program.")
    `RTIC_ASSERT_NEXT(a_cast_starts_copy, (state_reg == S_IDLE) && req_valid && operation, state_reg == S_COPY, "An accepted cast did not start the operand copy.")
    `RTIC_ASSERT_NEXT(a_div_returns, (state_reg == S_DIV) && status.div_done, (state_reg == S_FETCH) && (pc_reg == $past(pc_reg) + 1'b1), "Sequencer did not advance after a finished division.")

endmodule

>>> rtl/rtic_datapath.sv
// ============================================================================
// rtic_datapath
// Triangle store, operand register file, iterative multiplier, restoring
// divider and result register of the intersection core.
// ============================================================================
module rtic_datapath #(
    parameter int COORD_WIDTH    = 16,
    parameter int DIST_FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  rtic_pkg::req_t    req_data,
    input  rtic_pkg::cmd_t    cmd,
    output rtic_pkg::status_t status,
    output rtic_pkg::rsp_t    rsp_data
);

    localparam int WD    = 7*COORD_WIDTH + 16;
    localparam int RAW_W = (COORD_WIDTH > 16) ? COORD_WIDTH : 16;
    localparam int DEPTH = 2**rtic_pkg::ADDR_W;
    localparam int HS    = rtic_pkg::HIT_SUM_W;

    function automatic logic signed [COORD_WIDTH-1:0] coord(input logic [15:0] f);
        logic [RAW_W-1:0] raw;
        raw = RAW_W'(f);
        return raw[COORD_WIDTH-1:0];
    endfunction

    logic signed [COORD_WIDTH-1:0] vert_reg [3][3];
    logic signed [COORD_WIDTH-1:0] o_reg [3];
    logic signed [COORD_WIDTH-1:0] d_reg [3];
    logic signed [COORD_WIDTH-1:0] copy_src [15];

    logic [WD-1:0]                 mem [DEPTH];
    logic signed [WD-1:0]          rd_a_reg;
    logic signed [WD-1:0]          rd_b_reg;
    logic                          wr_en;
    logic [rtic_pkg::ADDR_W-1:0]   wr_addr;
    logic signed [WD-1:0]          wr_data;

    logic signed [WD-1:0]          ma_reg;
    logic signed [WD-1:0]          mb_reg;
    logic signed [WD-1:0]          acc_reg;
    logic [WD-1:0]                 part;
    logic                          mul_start;

    logic [WD-1:0]                 rem_reg;
    logic [WD-1:0]                 dsh_reg;
    logic [rtic_pkg::HIT_DIV_BITS-1:0] q_reg;
    logic [rtic_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          first_reg;
    logic [2:0]                    dtag_reg;
    logic                          ge;

    logic                          den_zero_reg;
    logic                          den_neg_reg;
    logic                          num_zero_reg;
    logic                          num_neg_reg;
    logic                          inside_reg;

    logic [31:0]                   dist_reg;
    logic signed [39:0]            hit_reg [3];
    logic [1:0]                    axis;
    logic signed [HS-1:0]          hit_sum;
    logic signed [39:0]            hit_sat;
    rtic_pkg::rsp_t                rsp_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                copy_src[3*i + a] = vert_reg[i][a];
            end
            copy_src[9 + i]  = o_reg[i];
            copy_src[12 + i] = d_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    vert_reg[i][a] <= '0;
                end
            end
        end
        else if (cmd.load_vertex && (req_data.vertex_slot != 2'd3))
        begin
            vert_reg[req_data.vertex_slot][0] <= coord(req_data.vert_x);
            vert_reg[req_data.vertex_slot][1] <= coord(req_data.vert_y);
            vert_reg[req_data.vertex_slot][2] <= coord(req_data.vert_z);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_ray)
        begin
            o_reg[0] <= coord(req_data.origin_x);
            o_reg[1] <= coord(req_data.origin_y);
            o_reg[2] <= coord(req_data.origin_z);
            d_reg[0] <= coord(req_data.dir_x);
            d_reg[1] <= coord(req_data.dir_y);
            d_reg[2] <= coord(req_data.dir_z);
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cmd.uop.dst;
        wr_data = acc_reg;
        if (cmd.copy_en)
        begin
            wr_en   = 1'b1;
            wr_addr = rtic_pkg::ADDR_W'(cmd.copy_idx);
            wr_data = WD'(copy_src[cmd.copy_idx]);
        end
        else if (cmd.exec)
        begin
            case (cmd.uop.op)
                rtic_pkg::OP_SUB:
                begin
                    wr_en   = 1'b1;
                    wr_data = rd_a_reg - rd_b_reg;
                end
                rtic_pkg::OP_ABS:
                begin
                    wr_en   = 1'b1;
                    wr_data = rd_a_reg[WD-1] ? -rd_a_reg : rd_a_reg;
                end
                rtic_pkg::OP_STORE:
                begin
                    wr_en = 1'b1;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[cmd.rd_a];
        rd_b_reg <= mem[cmd.rd_b];
    end

    assign mul_start = cmd.exec && ((cmd.uop.op == rtic_pkg::OP_MULC)
                                 || (cmd.uop.op == rtic_pkg::OP_MULA)
                                 || (cmd.uop.op == rtic_pkg::OP_MULS));

    always_comb
    begin
        part = (mb_reg[0] ? ma_reg        : '0)
             + (mb_reg[1] ? (ma_reg << 1) : '0)
             + (mb_reg[2] ? (ma_reg << 2) : '0)
             + (mb_reg[3] ? (ma_reg << 3) : '0);
    end

    always_ff @(posedge clk)
    begin
        if (mul_start)
        begin
            ma_reg <= (cmd.uop.op == rtic_pkg::OP_MULS) ? -rd_a_reg : rd_a_reg;
            mb_reg <= rd_b_reg;
            if (cmd.uop.op == rtic_pkg::OP_MULC)
            begin
                acc_reg <= '0;
            end
        end
        else if (cmd.mul_step)
        begin
            if (mb_reg == '1)
            begin
                acc_reg <= acc_reg - ma_reg;
                mb_reg  <= '0;
            end
            else
            begin
                acc_reg <= acc_reg + part;
                ma_reg  <= ma_reg << 4;
                mb_reg  <= mb_reg >>> 4;
            end
        end
    end

    assign ge = (rem_reg >= dsh_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.exec && (cmd.uop.op == rtic_pkg::OP_DIV))
        begin
            rem_reg  <= (cmd.uop.tag == rtic_pkg::TAG_DIST) ? (rd_a_reg << DIST_FRAC_BITS)
                                                            : (rd_a_reg << rtic_pkg::HIT_FRAC);
            dsh_reg  <= (cmd.uop.tag == rtic_pkg::TAG_DIST) ? (rd_b_reg << rtic_pkg::DIST_BITS)
                                                            : (rd_b_reg << rtic_pkg::HIT_DIV_BITS);
            q_reg    <= '0;
            dtag_reg <= cmd.uop.tag;
        end
        else if (cmd.div_step)
        begin
            dsh_reg <= dsh_reg >> 1;
            if (first_reg)
            begin
                if (ge)
                begin
                    q_reg <= '1;
                end
            end
            else if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
                q_reg   <= {q_reg[rtic_pkg::HIT_DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[rtic_pkg::HIT_DIV_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (cmd.exec && (cmd.uop.op == rtic_pkg::OP_DIV))
        begin
            first_reg <= 1'b1;
            cnt_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            first_reg <= 1'b0;
            if (first_reg)
            begin
                if (ge)
                begin
                    cnt_reg <= '0;
                end
                else if (dtag_reg == rtic_pkg::TAG_DIST)
                begin
                    cnt_reg <= rtic_pkg::DIV_CNT_W'(rtic_pkg::DIST_BITS);
                end
                else
                begin
                    cnt_reg <= rtic_pkg::DIV_CNT_W'(rtic_pkg::HIT_DIV_BITS);
                end
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    assign status.mul_done = (mb_reg == '0);
    assign status.div_done = !first_reg && (cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            den_zero_reg <= 1'b0;
            den_neg_reg  <= 1'b0;
            num_zero_reg <= 1'b0;
            num_neg_reg  <= 1'b0;
            inside_reg   <= 1'b0;
        end
        else if (cmd.load_ray)
        begin
            inside_reg <= 1'b1;
        end
        else if (cmd.exec && (cmd.uop.op == rtic_pkg::OP_STORE))
        begin
            case (cmd.uop.tag)
                rtic_pkg::TAG_DEN:
                begin
                    den_zero_reg <= (acc_reg == '0);
                    den_neg_reg  <= acc_reg[WD-1];
                end
                rtic_pkg::TAG_NUM:
                begin
                    num_zero_reg <= (acc_reg == '0);
                    num_neg_reg  <= acc_reg[WD-1];
                end
                rtic_pkg::TAG_TV:
                begin
                    if (den_neg_reg ? (!acc_reg[WD-1] && (acc_reg != '0)) : acc_reg[WD-1])
                    begin
                        inside_reg <= 1'b0;
                    end
                end
                default:
                begin
                    inside_reg <= inside_reg;
                end
            endcase
        end
    end

    assign axis = dtag_reg[1:0] - rtic_pkg::TAG_HX[1:0];

    always_comb
    begin
        hit_sum = (HS'(o_reg[axis]) <<< rtic_pkg::HIT_FRAC)
                + (d_reg[axis][COORD_WIDTH-1] ? -$signed(HS'(q_reg)) : $signed(HS'(q_reg)));
        if (hit_sum > rtic_pkg::HIT_MAX)
        begin
            hit_sat = rtic_pkg::HIT_MAX[39:0];
        end
        else if (hit_sum < rtic_pkg::HIT_MIN)
        begin
            hit_sat = rtic_pkg::HIT_MIN[39:0];
        end
        else
        begin
            hit_sat = hit_sum[39:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_commit)
        begin
            if (dtag_reg == rtic_pkg::TAG_DIST)
            begin
                dist_reg <= q_reg[31:0];
            end
            else
            begin
                hit_reg[axis] <= hit_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (den_zero_reg)
            begin
                rsp_reg         <= '0;
                rsp_reg.outcome <= rtic_pkg::OUTCOME_PARALLEL;
            end
            else if (!num_zero_reg && (num_neg_reg != den_neg_reg))
            begin
                rsp_reg         <= '0;
                rsp_reg.outcome <= rtic_pkg::OUTCOME_BEHIND;
            end
            else
            begin
                rsp_reg.hit      <= inside_reg;
                rsp_reg.outcome  <= inside_reg ? rtic_pkg::OUTCOME_HIT
                                               : rtic_pkg::OUTCOME_OUTSIDE;
                rsp_reg.distance <= dist_reg;
                rsp_reg.hit_x    <= hit_reg[0];
                rsp_reg.hit_y    <= hit_reg[1];
                rsp_reg.hit_z    <= hit_reg[2];
            end
        end
    end

    assign rsp_data = rsp_reg;

endmodule
